@@ rtl/xs256_pkg.sv @@
package xs256_pkg;

	// Operation codes carried in the func field
	localparam logic [1:0] FUNC_NEXT = 2'd0;
	localparam logic [1:0] FUNC_SEED = 2'd1;
	localparam logic [1:0] FUNC_JUMP = 2'd2;

	// Splitmix64 constants
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

	// Jump polynomial, bit n of the walk is JUMP_POLY[n]
	localparam logic [255:0] JUMP_POLY = {
		64'h39ab_dc45_29b1_661c, 64'ha958_2618_e03f_c9aa,
		64'hd5a6_1266_f0c9_392c, 64'h180e_c6d3_3cfd_0aba
	};

	// Datapath operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_NEXT,
		DP_SEED_LOAD,
		DP_SEED_ADD,
		DP_MUL,
		DP_SEED_MIX,
		DP_SEED_STORE,
		DP_JUMP_STEP,
		DP_JUMP_LAST
	} dp_op_t;

	// Command bundle from controller to datapath
	typedef struct packed {
		dp_op_t     op;
		logic       load_zero;  // load a zero result into the output register
		logic       mul_sel_b;  // 0: MIX_MUL_A, 1: MIX_MUL_B
		logic [1:0] phase;      // partial-product phase of the 64-bit multiply
		logic [1:0] word;       // state word being seeded
		logic       poly_bit;   // jump polynomial bit for this step
	} cmd_t;

endpackage

@@ rtl/xs256_req_if.sv @@
interface xs256_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [63:0] seed_value;

	modport source (output valid, output func, output seed_value, input ready);
	modport sink (input valid, input func, input seed_value, output ready);
endinterface

@@ rtl/xs256_rsp_if.sv @@
interface xs256_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_value;
	logic [51:0] unit_fraction;

	modport source (output valid, output random_value, output unit_fraction, input ready);
	modport sink (input valid, input random_value, input unit_fraction, output ready);
endinterface

@@ rtl/xs256_datapath.sv @@
module xs256_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  xs256_pkg::cmd_t  cmd,
	input  logic [63:0]      seed_value,
	output logic [63:0]      random_value
);
	import xs256_pkg::*;

	logic [63:0] words_q [4];
	logic [63:0] jacc_q [4];
	logic [63:0] seed_q;
	logic [63:0] z_q;
	logic [63:0] prod_q;
	logic [63:0] out_q;

	logic [63:0] sum;
	logic [63:0] adv [4];
	logic [63:0] jacc_nxt [4];
	logic [63:0] seed_sum;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] mul_k;
	logic [63:0] mul_p;

	// xoshiro256+ output and state update
	always_comb begin
		logic [63:0] t;
		logic [63:0] n0;
		logic [63:0] n1;
		logic [63:0] n2;
		logic [63:0] n3;
		sum = words_q[0] + words_q[3];
		t = {words_q[1][46:0], 17'd0};
		n2 = words_q[2] ^ words_q[0];
		n3 = words_q[3] ^ words_q[1];
		n1 = words_q[1] ^ n2;
		n0 = words_q[0] ^ n3;
		adv[0] = n0;
		adv[1] = n1;
		adv[2] = n2 ^ t;
		adv[3] = {n3[18:0], n3[63:19]};
	end

	// Jump accumulation: xor the state in where the polynomial bit is set
	always_comb begin
		for (int w = 0; w < 4; w++) begin
			jacc_nxt[w] = jacc_q[w] ^ (cmd.poly_bit ? words_q[w] : 64'd0);
		end
	end

	// Splitmix64 increment
	assign seed_sum = seed_q + GOLDEN_GAMMA;

	// Shared 32x32 multiplier, three partial products per 64-bit multiply
	assign mul_k = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
	assign mul_x = (cmd.phase == 2'd1) ? z_q[63:32] : z_q[31:0];
	assign mul_y = (cmd.phase == 2'd2) ? mul_k[63:32] : mul_k[31:0];
	assign mul_p = 64'(mul_x) * 64'(mul_y);

	// Jump accumulators, seed register (cleared so reset seeds from zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < 4; w++) begin
				jacc_q[w] <= 64'd0;
			end
			seed_q <= 64'd0;
		end else begin
			unique case (cmd.op)
				DP_SEED_LOAD: seed_q <= seed_value;
				DP_SEED_ADD:  seed_q <= seed_sum;
				DP_JUMP_STEP: jacc_q <= jacc_nxt;
				DP_JUMP_LAST: begin
					for (int w = 0; w < 4; w++) begin
						jacc_q[w] <= 64'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// State words and seeding work registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_NEXT:       words_q <= adv;
			DP_SEED_ADD:   z_q <= seed_sum ^ (seed_sum >> 30);
			DP_MUL: begin
				if (cmd.phase == 2'd0) begin
					prod_q <= mul_p;
				end else begin
					prod_q <= prod_q + {mul_p[31:0], 32'd0};
				end
			end
			DP_SEED_MIX:   z_q <= prod_q ^ (prod_q >> 27);
			DP_SEED_STORE: words_q[cmd.word] <= prod_q ^ (prod_q >> 31);
			DP_JUMP_STEP:  words_q <= adv;
			DP_JUMP_LAST:  words_q <= jacc_nxt;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_zero) begin
			out_q <= 64'd0;
		end else if (cmd.op == DP_NEXT) begin
			out_q <= sum;
		end
	end

	assign random_value = out_q;

endmodule

@@ rtl/xs256_ctrl.sv @@
module xs256_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_func,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output xs256_pkg::cmd_t  cmd
);
	import xs256_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE       = 7'b0000001,
		ST_SEED_ADD   = 7'b0000010,
		ST_SEED_MUL_A = 7'b0000100,
		ST_SEED_MIX   = 7'b0001000,
		ST_SEED_MUL_B = 7'b0010000,
		ST_SEED_STORE = 7'b0100000,
		ST_JUMP       = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic [1:0] word_q, word_d;
	logic [7:0] jidx_q, jidx_d;
	logic       init_q, init_d;
	logic       out_valid_q, out_valid_d;
	logic       accept;

	assign req_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	// Sequencer
	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		word_d        = word_q;
		jidx_d        = jidx_q;
		init_d        = init_q;
		cmd.op        = DP_NOP;
		cmd.load_zero = 1'b0;
		cmd.mul_sel_b = 1'b0;
		cmd.phase     = phase_q;
		cmd.word      = word_q;
		cmd.poly_bit  = JUMP_POLY[jidx_q];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_func)
						FUNC_NEXT: cmd.op = DP_NEXT;
						FUNC_SEED: begin
							cmd.op  = DP_SEED_LOAD;
							word_d  = 2'd0;
							state_d = ST_SEED_ADD;
						end
						FUNC_JUMP: begin
							jidx_d  = 8'd0;
							state_d = ST_JUMP;
						end
						default: cmd.load_zero = 1'b1;
					endcase
				end
			end
			ST_SEED_ADD: begin
				cmd.op  = DP_SEED_ADD;
				phase_d = 2'd0;
				state_d = ST_SEED_MUL_A;
			end
			ST_SEED_MUL_A: begin
				cmd.op = DP_MUL;
				if (phase_q == 2'd2) begin
					phase_d = 2'd0;
					state_d = ST_SEED_MIX;
				end else begin
					phase_d = phase_q + 2'd1;
				end
			end
			ST_SEED_MIX: begin
				cmd.op  = DP_SEED_MIX;
				phase_d = 2'd0;
				state_d = ST_SEED_MUL_B;
			end
			ST_SEED_MUL_B: begin
				cmd.op        = DP_MUL;
				cmd.mul_sel_b = 1'b1;
				if (phase_q == 2'd2) begin
					phase_d = 2'd0;
					state_d = ST_SEED_STORE;
				end else begin
					phase_d = phase_q + 2'd1;
				end
			end
			ST_SEED_STORE: begin
				cmd.op = DP_SEED_STORE;
				if (word_q == 2'd3) begin
					// the power-up seeding gives no result
					cmd.load_zero = !init_q;
					init_d        = 1'b0;
					word_d        = 2'd0;
					state_d       = ST_IDLE;
				end else begin
					word_d  = word_q + 2'd1;
					state_d = ST_SEED_ADD;
				end
			end
			ST_JUMP: begin
				jidx_d = jidx_q + 8'd1;
				if (jidx_q == 8'd255) begin
					cmd.op        = DP_JUMP_LAST;
					cmd.load_zero = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.op = DP_JUMP_STEP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output slot: filled by a result load, emptied by a transfer
	always_comb begin
		if (cmd.load_zero || cmd.op == DP_NEXT) begin
			out_valid_d = 1'b1;
		end else if (rsp_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// Reset starts the seeding sequence from seed zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED_ADD;
			phase_q     <= 2'd0;
			word_q      <= 2'd0;
			jidx_q      <= 8'd0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			word_q      <= word_d;
			jidx_q      <= jidx_d;
			init_q      <= init_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

	a_jidx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_JUMP) |-> (jidx_q == 8'd0))
		else $error("jump index not zero outside a jump");

	a_jump_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_JUMP && jidx_q == 8'd255) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("jump end did not post a result");

	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !req_ready && !out_valid_q)
		else $error("item taken during power-up seeding");

endmodule

@@ rtl/xoshiro256_plus_generator_core.sv @@
// xoshiro256+ random number generator with splitmix64 seeding.
//
// Channels: req carries func (0 next, 1 reseed from seed_value, 2 jump
// ahead 2^128, 3 no operation) and seed_value; rsp carries random_value and
// unit_fraction (random_value >> 12, a U0.52 fraction in [0,1)). Every
// request gives exactly one response; all but next respond with zeros.
//
// Next: the result is registered at the transfer and offered in the next cycle.
// Back-to-back next requests run at one per cycle while rsp is ready.
// Reseed: 4 words x 9 steps on one shared 32x32 multiplier, three partial
// products per 64-bit multiply. Jump: one polynomial bit per cycle.
// req.ready stays low while either runs.
//
// Reset: the state is seeded from zero by the same sequence;
// req.ready stays low until it is done and no response is produced.
// When rsp stalls, the pending response holds in the output register and
// req.ready drops until the response transfers.
module xoshiro256_plus_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	xs256_req_if.sink   req,
	xs256_rsp_if.source rsp
);
	import xs256_pkg::*;

	cmd_t cmd;

	xs256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	xs256_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.seed_value   (req.seed_value),
		.random_value (rsp.random_value)
	);

	assign rsp.unit_fraction = rsp.random_value[63:12];

endmodule

@@ test/xs256_draw_checker.sv @@
// Watches both channels, keeps its own copy of the generator state and
// compares each response transfer with the oldest predicted draw.
module xs256_draw_checker (
	input  logic clk,
	input  logic arst_n,
	xs256_req_if req,
	xs256_rsp_if rsp,
	output int   mismatches,
	output int   outstanding
);
	import xs256_pkg::*;

	typedef struct packed {
		logic [63:0] random_value;
		logic [51:0] unit_fraction;
	} draw_t;

	logic [63:0] gen_words [4];
	draw_t       draw_q [$];

	// One splitmix64 output from an already advanced counter
	function automatic logic [63:0] splitmix_out(input logic [63:0] ctr);
		logic [63:0] z;
		z = ctr;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	task automatic reseed_words(input logic [63:0] seed);
		logic [63:0] ctr;
		ctr = seed;
		for (int w = 0; w < 4; w++) begin
			ctr = ctr + GOLDEN_GAMMA;
			gen_words[w] = splitmix_out(ctr);
		end
	endtask

	// xoshiro256+ step: sum taken before the update
	task automatic advance_words(output logic [63:0] sum);
		logic [63:0] t;
		sum = gen_words[0] + gen_words[3];
		t = gen_words[1] << 17;
		gen_words[2] ^= gen_words[0];
		gen_words[3] ^= gen_words[1];
		gen_words[1] ^= gen_words[2];
		gen_words[0] ^= gen_words[3];
		gen_words[2] ^= t;
		gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
	endtask

	// Jump ahead 2^128 steps: xor-accumulate the state where the polynomial bit is set
	task automatic jump_words();
		logic [63:0] acc [4];
		logic [63:0] unused_sum;
		for (int w = 0; w < 4; w++)
			acc[w] = '0;
		for (int n = 0; n < 256; n++) begin
			if (JUMP_POLY[n]) begin
				for (int w = 0; w < 4; w++)
					acc[w] ^= gen_words[w];
			end
			advance_words(unused_sum);
		end
		for (int w = 0; w < 4; w++)
			gen_words[w] = acc[w];
	endtask

	task automatic predict_draw(input logic [1:0] func, input logic [63:0] seed_value,
			output draw_t d);
		logic [63:0] sum;
		d = '0;
		case (func)
			FUNC_NEXT: begin
				advance_words(sum);
				d.random_value  = sum;
				d.unit_fraction = sum[63:12];
			end
			FUNC_SEED: begin
				reseed_words(seed_value);
			end
			FUNC_JUMP: begin
				jump_words();
			end
			default: begin
			end
		endcase
	endtask

	// Response transfers are checked before the request of the same edge is predicted;
	// a response never belongs to a request accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		draw_t want;
		draw_t got;
		int    bad;
		if (!arst_n) begin
			reseed_words(64'd0);
			draw_q.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (rsp.valid && rsp.ready) begin
				got.random_value  = rsp.random_value;
				got.unit_fraction = rsp.unit_fraction;
				if (draw_q.size() == 0) begin
					$display("%0t: unexpected response, random_value %h unit_fraction %h",
						$time, got.random_value, got.unit_fraction);
					bad++;
				end else begin
					want = draw_q.pop_front();
					if (got.random_value !== want.random_value) begin
						$display("%0t: random_value expected %h actual %h",
							$time, want.random_value, got.random_value);
						bad++;
					end
					if (got.unit_fraction !== want.unit_fraction) begin
						$display("%0t: unit_fraction expected %h actual %h",
							$time, want.unit_fraction, got.unit_fraction);
						bad++;
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_draw(req.func, req.seed_value, want);
				draw_q.push_back(want);
			end
			mismatches  <= mismatches + bad;
			outstanding <= draw_q.size();
		end
	end

endmodule

@@ test/xoshiro256_plus_generator_core_tb.sv @@
module xoshiro256_plus_generator_core_tb;
	import xs256_pkg::*;

	// Spare operation code: no state change, zero response
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int RANDOM_ITEMS   = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   idle_cycles;
	bit   hold_rsp;
	bit   quiet;

	xs256_req_if req ();
	xs256_rsp_if rsp ();

	xoshiro256_plus_generator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	xs256_draw_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request and hold it until it transfers
	task automatic send_item(input logic [1:0] func, input logic [63:0] seed_value);
		req.valid      <= 1'b1;
		req.func       <= func;
		req.seed_value <= seed_value;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic idle_req(input int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_draws();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Response side: random stall bursts, one long hold-off on request
	initial begin
		bit long_done;
		long_done = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_rsp && !long_done) begin
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Request side
	initial begin
		logic [1:0]  func;
		logic [63:0] seed_value;
		int          pick;
		hold_rsp        = 1'b0;
		quiet           = 1'b0;
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.func       <= FUNC_NEXT;
		req.seed_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: state after reset, extreme seeds, spare code, jumps
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_NEXT, '1);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SPARE, 64'd0);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SEED, 64'd0);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SEED, '1);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SEED, 64'h8000_0000_0000_0000);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SEED, 64'h5555_5555_5555_5555);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SEED, 64'haaaa_aaaa_aaaa_aaaa);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SEED, 64'd1);
		send_item(FUNC_JUMP, '1);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_JUMP, 64'd0);
		send_item(FUNC_NEXT, 64'd0);
		send_item(FUNC_SPARE, '1);
		send_item(FUNC_NEXT, 64'd0);
		idle_req(1);

		// Random: mostly draws, some reseeds, a few jumps and spare codes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 150)
				hold_rsp = 1'b1;
			if (i == 350)
				drain_draws();
			if (i == 500)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 78)
				func = FUNC_NEXT;
			else if (pick < 90)
				func = FUNC_SEED;
			else if (pick < 94)
				func = FUNC_JUMP;
			else
				func = FUNC_SPARE;
			case ($urandom_range(0, 7))
				0:       seed_value = '0;
				1:       seed_value = '1;
				default: seed_value = {$urandom, $urandom};
			endcase
			send_item(func, seed_value);
			if (!quiet && $urandom_range(0, 3) == 0)
				idle_req($urandom_range(1, 10));
		end

		// Wind down
		drain_draws();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/xs256_pkg.sv
rtl/xs256_req_if.sv
rtl/xs256_rsp_if.sv
rtl/xs256_datapath.sv
rtl/xs256_ctrl.sv
rtl/xoshiro256_plus_generator_core.sv
test/xs256_draw_checker.sv
test/xoshiro256_plus_generator_core_tb.sv
